// ===== hw/rtl/rrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrtp_pkg
// Command codes and controller/datapath interface types for the
// round-robin task picker.
// ----------------------------------------------------------------------------
package rrtp_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_SLEEP  = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic update;
    logic save;
    logic scan;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } stat_t;

endpackage

// ===== hw/rtl/rrtp_ram.sv =====
// ----------------------------------------------------------------------------
// rrtp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rrtp_dp.sv =====
// ----------------------------------------------------------------------------
// rrtp_dp
// Datapath: slot flags, sleep and pointer memories, scan index, tick
// counter and result registers.
// ----------------------------------------------------------------------------
module rrtp_dp
  import rrtp_pkg::*;
#(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output stat_t       stat,
  input  logic [1:0]  cmd,
  input  logic [2:0]  task_slot,
  input  logic [31:0] pointer_value,
  input  logic [31:0] sleep_ticks,
  output logic        found,
  output logic [2:0]  next_task,
  output logic [31:0] next_pointer,
  output logic [31:0] tick_count
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  cmd_t              cmd_q;
  logic [2:0]        slot_q;
  logic [31:0]       ptr_q;
  logic [31:0]       ticks_q;

  logic [TASK_SLOTS-1:0] alloc;
  logic [TASK_SLOTS-1:0] pend;
  logic [TASK_SLOTS-1:0] svalid;
  logic                  rd_valid;

  logic [IDX_W-1:0]  running_slot;
  logic              running_valid;
  logic [31:0]       tick_counter;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  step;

  logic              slot_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [31:0]       cnt;
  logic              hit;
  logic              last;

  logic              sl_we;
  logic [IDX_W-1:0]  sl_waddr;
  logic [31:0]       sl_wdata;
  logic [31:0]       sl_rdata;
  logic              pt_we;
  logic [IDX_W-1:0]  pt_waddr;
  logic [31:0]       pt_wdata;
  logic [31:0]       pt_rdata;

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] x);
    inc_idx = (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  assign slot_ok   = int'(slot_q) < TASK_SLOTS;
  assign slot_idx  = IDX_W'(slot_q);
  assign start_idx = running_valid ? inc_idx(running_slot) : '0;
  assign cnt       = rd_valid ? sl_rdata : 32'd0;
  assign hit       = alloc[scan_idx] && (cnt == 32'd0);
  assign last      = (step == LAST_IDX);
  assign stat      = '{hit: hit, last: last};
  assign tick_count = tick_counter;

  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = scan_idx;
    sl_wdata = cnt - 32'd1;
    pt_we    = 1'b0;
    pt_waddr = running_slot;
    pt_wdata = ptr_q;
    rd_addr  = scan_idx;
    if (ctl.update && slot_ok) begin
      sl_waddr = slot_idx;
      pt_waddr = slot_idx;
      case (cmd_q)
        CMD_CREATE: begin
          sl_we    = 1'b1;
          sl_wdata = 32'd0;
          pt_we    = 1'b1;
        end
        CMD_SLEEP: begin
          sl_we    = 1'b1;
          sl_wdata = ticks_q;
        end
        default: begin
        end
      endcase
    end
    if (ctl.save) begin
      pt_we   = running_valid;
      rd_addr = start_idx;
    end
    if (ctl.scan) begin
      sl_we   = !hit && (cnt != 32'd0);
      rd_addr = inc_idx(scan_idx);
    end
  end

  rrtp_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_sleep_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (rd_addr),
    .rdata (sl_rdata)
  );

  rrtp_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_ptr_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (rd_addr),
    .rdata (pt_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= cmd_t'(cmd);
      slot_q  <= task_slot;
      ptr_q   <= pointer_value;
      ticks_q <= sleep_ticks;
    end
    if (ctl.scan) begin
      if (hit) begin
        found        <= 1'b1;
        next_task    <= 3'(scan_idx);
        next_pointer <= pt_rdata;
      end else if (last) begin
        found        <= 1'b0;
        next_task    <= 3'd0;
        next_pointer <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc         <= '0;
      pend          <= '0;
      svalid        <= '0;
      rd_valid      <= 1'b0;
      running_slot  <= '0;
      running_valid <= 1'b0;
      tick_counter  <= 32'd0;
      scan_idx      <= '0;
      step          <= '0;
    end else begin
      rd_valid <= svalid[rd_addr];
      if (sl_we) begin
        svalid[sl_waddr] <= 1'b1;
      end
      if (ctl.update && slot_ok) begin
        case (cmd_q)
          CMD_CREATE: begin
            alloc[slot_idx] <= 1'b1;
            pend[slot_idx]  <= 1'b0;
          end
          CMD_DELETE: pend[slot_idx] <= 1'b1;
          default: begin
          end
        endcase
      end
      if (ctl.save) begin
        alloc        <= alloc & ~pend;
        pend         <= '0;
        tick_counter <= tick_counter + 32'd1;
        scan_idx     <= start_idx;
        step         <= '0;
      end
      if (ctl.scan) begin
        scan_idx <= inc_idx(scan_idx);
        step     <= step + 1'b1;
        if (hit) begin
          running_slot  <= scan_idx;
          running_valid <= 1'b1;
        end else if (last) begin
          running_valid <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rrtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrtp_ctrl
// Controller: accepts items, sequences slot updates and the tick scan,
// and raises the result strobe.
// ----------------------------------------------------------------------------
module rrtp_ctrl
  import rrtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  output logic       busy,
  output logic       done,
  output ctl_t       ctl,
  input  stat_t      stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SAVE,
    S_SCAN
  } state_t;

  state_t state;

  assign ctl.load   = start && !busy;
  assign ctl.update = (state == S_UPDATE);
  assign ctl.save   = (state == S_SAVE);
  assign ctl.scan   = (state == S_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= (cmd_t'(cmd) == CMD_TICK) ? S_SAVE : S_UPDATE;
          end
        end
        S_UPDATE: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_SAVE: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.hit || stat.last) begin
            busy  <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/round_robin_task_picker.sv =====
// Tick: the scan checks one slot per cycle, from the slot after the running
// task (slot 0 if none), up to TASK_SLOTS slots, then strobes the result.
// Create, sleep and delete: busy for one cycle, no result.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Synchronous reset clears slot flags, sleep counters, running task and
// tick counter; the pointer memory is not cleared.
// ----------------------------------------------------------------------------
// round_robin_task_picker
// Task slot table with sleep counters and a round-robin scheduler tick.
// ----------------------------------------------------------------------------
module round_robin_task_picker
  import rrtp_pkg::*;
#(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [2:0]  task_slot,
  input  logic [31:0] pointer_value,
  input  logic [31:0] sleep_ticks,
  output logic        done,
  output logic        found,
  output logic [2:0]  next_task,
  output logic [31:0] next_pointer,
  output logic [31:0] tick_count
);

  ctl_t  ctl;
  stat_t stat;

  rrtp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .stat  (stat)
  );

  rrtp_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cmd           (cmd),
    .task_slot     (task_slot),
    .pointer_value (pointer_value),
    .sleep_ticks   (sleep_ticks),
    .found         (found),
    .next_task     (next_task),
    .next_pointer  (next_pointer),
    .tick_count    (tick_count)
  );

endmodule

// ===== verif/tb_round_robin_task_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_picker
// Self-checking bench for the round-robin task picker. Commands are issued
// through the start/busy handshake and mirrored into a scoreboard that keeps
// its own slot table and predicts every pick; each done strobe is checked
// against the oldest pending pick. A short directed sequence is followed by
// random create/sleep/delete/tick traffic under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_round_robin_task_picker
  import rrtp_pkg::*;
();

  localparam int SLOTS        = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = SLOTS + 6;
  localparam int RANDOM_ITEMS = 700;

  typedef struct {
    bit        found;
    bit [2:0]  next_task;
    bit [31:0] next_pointer;
    bit [31:0] tick_count;
  } pick_t;

  class pick_scoreboard;
    bit        allocated [SLOTS];
    bit        delete_mark [SLOTS];
    bit [31:0] sleep_count [SLOTS];
    bit [31:0] saved_pointer [SLOTS];
    bit [2:0]  running_slot;
    bit        running_valid;
    bit [31:0] ticks_seen;
    pick_t     expected_picks [$];
    int        errors;

    function pick_t pick_next(bit [31:0] outgoing);
      pick_t p;
      int    first;
      int    idx;
      bit    hit;
      if (running_valid) saved_pointer[running_slot] = outgoing;
      ticks_seen++;
      for (int i = 0; i < SLOTS; i++) begin
        if (delete_mark[i]) begin
          delete_mark[i] = 1'b0;
          allocated[i] = 1'b0;
        end
      end
      first = running_valid ? int'(running_slot) : SLOTS - 1;
      hit = 1'b0;
      idx = 0;
      for (int step = 0; step < SLOTS && !hit; step++) begin
        idx = (first + step + 1) % SLOTS;
        if (allocated[idx] && sleep_count[idx] == 0) begin
          hit = 1'b1;
        end else if (sleep_count[idx] != 0) begin
          sleep_count[idx]--;
        end
      end
      p.tick_count = ticks_seen;
      if (hit) begin
        running_slot = idx[2:0];
        running_valid = 1'b1;
        p.found = 1'b1;
        p.next_task = idx[2:0];
        p.next_pointer = saved_pointer[idx];
      end else begin
        running_valid = 1'b0;
        p.found = 1'b0;
        p.next_task = '0;
        p.next_pointer = '0;
      end
      return p;
    endfunction

    function void note_item(cmd_t c, bit [2:0] slot, bit [31:0] ptr, bit [31:0] ticks);
      case (c)
        CMD_TICK: expected_picks.push_back(pick_next(ptr));
        CMD_CREATE: begin
          allocated[slot] = 1'b1;
          delete_mark[slot] = 1'b0;
          sleep_count[slot] = '0;
          saved_pointer[slot] = ptr;
        end
        CMD_SLEEP: sleep_count[slot] = ticks;
        CMD_DELETE: delete_mark[slot] = 1'b1;
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic f, logic [2:0] t, logic [31:0] p, logic [31:0] n);
      pick_t e;
      if (expected_picks.size() == 0) begin
        report_mismatch("result strobe with no pick pending");
        return;
      end
      e = expected_picks.pop_front();
      if (f !== e.found)
        report_mismatch($sformatf("found %b, expected %b", f, e.found));
      if (t !== e.next_task)
        report_mismatch($sformatf("next_task %0d, expected %0d", t, e.next_task));
      if (p !== e.next_pointer)
        report_mismatch($sformatf("next_pointer %h, expected %h", p, e.next_pointer));
      if (n !== e.tick_count)
        report_mismatch($sformatf("tick_count %0d, expected %0d", n, e.tick_count));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [2:0]  task_slot;
  logic [31:0] pointer_value;
  logic [31:0] sleep_ticks;
  logic        done;
  logic        found;
  logic [2:0]  next_task;
  logic [31:0] next_pointer;
  logic [31:0] tick_count;

  pick_scoreboard sb;
  int             cycles;

  round_robin_task_picker #(
    .TASK_SLOTS(SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .task_slot    (task_slot),
    .pointer_value(pointer_value),
    .sleep_ticks  (sleep_ticks),
    .done         (done),
    .found        (found),
    .next_task    (next_task),
    .next_pointer (next_pointer),
    .tick_count   (tick_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) sb.check_result(found, next_task, next_pointer, tick_count);
      if (start && busy === 1'b0) sb.note_item(cmd_t'(cmd), task_slot, pointer_value, sleep_ticks);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(cmd_t c, bit [2:0] slot, bit [31:0] ptr, bit [31:0] ticks);
    start <= 1'b1;
    cmd <= c;
    task_slot <= slot;
    pointer_value <= ptr;
    sleep_ticks <= ticks;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_for_picks();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_picks.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int        r;
    bit [31:0] ticks;
    r = $urandom_range(99);
    if ($urandom_range(99) < 70) ticks = $urandom_range(0, 6);
    else if ($urandom_range(99) < 50) ticks = $urandom_range(0, 40);
    else if ($urandom_range(99) < 80) ticks = $urandom;
    else ticks = 32'hffff_ffff;
    if (r < 40) send_item(CMD_TICK, 3'($urandom_range(0, 7)), $urandom, $urandom);
    else if (r < 62) send_item(CMD_CREATE, 3'($urandom_range(0, 7)), $urandom, $urandom);
    else if (r < 82) send_item(CMD_SLEEP, 3'($urandom_range(0, 7)), $urandom, ticks);
    else send_item(CMD_DELETE, 3'($urandom_range(0, 7)), $urandom, $urandom);
  endtask

  initial begin
    int idle_pct [4];
    sb = new();
    cycles = 0;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_TICK;
    task_slot = '0;
    pointer_value = '0;
    sleep_ticks = '0;
    idle_pct = '{0, 55, 0, 28};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table, nothing running
    send_item(CMD_TICK, 3'd0, 32'h0000_0000, 32'h0);
    send_item(CMD_CREATE, 3'd0, 32'h0000_0000, 32'hffff_ffff);
    send_item(CMD_CREATE, 3'd7, 32'hffff_ffff, 32'h0);
    send_item(CMD_TICK, 3'd7, 32'h1234_5678, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'hffff_ffff, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'h0000_0000, 32'h0);
    send_item(CMD_SLEEP, 3'd7, 32'h0, 32'hffff_ffff);
    // sleep on a free slot still counts down
    send_item(CMD_SLEEP, 3'd3, 32'h0, 32'd2);
    send_item(CMD_TICK, 3'd0, 32'ha5a5_a5a5, 32'h0);
    // delete the running task, then nothing is ready
    send_item(CMD_DELETE, 3'd0, 32'h0, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'h5a5a_5a5a, 32'h0);
    send_item(CMD_DELETE, 3'd5, 32'h0, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'h0, 32'h0);
    send_item(CMD_CREATE, 3'd7, 32'hdead_beef, 32'h0);
    send_item(CMD_CREATE, 3'd2, 32'h0f0f_0f0f, 32'h0);
    send_item(CMD_SLEEP, 3'd2, 32'h0, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'h0, 32'h0);
    send_item(CMD_CREATE, 3'd4, 32'hf0f0_f0f0, 32'h0);
    send_item(CMD_SLEEP, 3'd4, 32'h0, 32'd1);
    send_item(CMD_TICK, 3'd0, 32'h8000_0001, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'h7fff_fffe, 32'h0);
    send_item(CMD_DELETE, 3'd2, 32'h0, 32'h0);
    send_item(CMD_DELETE, 3'd7, 32'h0, 32'h0);
    send_item(CMD_DELETE, 3'd4, 32'h0, 32'h0);
    send_item(CMD_TICK, 3'd0, 32'h0, 32'h0);
    wait_for_picks();

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        random_item();
        sender_gap(idle_pct[ph]);
      end
      wait_for_picks();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_picks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
